### src/sctok_pkg.sv
// sctok_pkg: shared types, constants and character-class helpers for the
// source character tokenizer. No dependencies.
package sctok_pkg;

	// Default widths of the position and length counters
	localparam int unsigned POSITION_BITS_DEF = 20;
	localparam int unsigned LENGTH_BITS_DEF   = 16;

	// Keyword table
	localparam int unsigned NUM_KW     = 5;
	localparam int unsigned KW_MAX_LEN = 6;

	// Result queue geometry
	localparam int unsigned RQ_DEPTH    = 4;
	localparam int unsigned RQ_PTR_BITS = $clog2(RQ_DEPTH);
	localparam int unsigned RQ_LVL_BITS = $clog2(RQ_DEPTH + 1);

	typedef enum logic [2:0] {
		KIND_KEYWORD = 3'd0,
		KIND_IDENT   = 3'd1,
		KIND_NUMBER  = 3'd2,
		KIND_PUNCT   = 3'd3,
		KIND_EOF     = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		SCAN_IDLE   = 2'd0,
		SCAN_IDENT  = 2'd1,
		SCAN_NUMBER = 2'd2
	} scan_mode_t;

	typedef logic [2:0] kw_idx_t;

	// Queue status seen by the input stage
	typedef struct packed {
		logic [RQ_LVL_BITS-1:0] level;
		logic                   room;
	} rq_stat_t;

	// Keyword spellings, zero padded: class, public, static, void, int
	localparam logic [7:0] KW_CHARS [NUM_KW][KW_MAX_LEN] = '{
		'{"c", "l", "a", "s", "s", 8'h00},
		'{"p", "u", "b", "l", "i", "c"},
		'{"s", "t", "a", "t", "i", "c"},
		'{"v", "o", "i", "d", 8'h00, 8'h00},
		'{"i", "n", "t", 8'h00, 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd5, 3'd6, 3'd6, 3'd4, 3'd3};

	localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
	localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == CHAR_UNDERSCORE);
	endfunction

endpackage

### src/sctok_byte_if.sv
// sctok_byte_if: input channel of the tokenizer, one source byte or an
// end marker per item. Depends on nothing.
interface sctok_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       is_end;

	modport source (output valid, output ch, output is_end, input ready);
	modport sink (input valid, input ch, input is_end, output ready);
endinterface

### src/sctok_tok_if.sv
// sctok_tok_if: token channel of the tokenizer, one token report per item.
// Depends on sctok_pkg for default widths.
interface sctok_tok_if import sctok_pkg::*; #(
	parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
	parameter int unsigned LENGTH_BITS   = LENGTH_BITS_DEF
);
	logic                     valid;
	logic                     ready;
	logic [2:0]               kind;
	logic [LENGTH_BITS-1:0]   token_length;
	logic [POSITION_BITS-1:0] start_line;
	logic [POSITION_BITS-1:0] start_column;
	logic [2:0]               keyword_index;
	logic [7:0]               punct_byte;
	logic                     last_of_run;

	modport source (
		output valid, output kind, output token_length, output start_line,
		output start_column, output keyword_index, output punct_byte,
		output last_of_run, input ready
	);
	modport sink (
		input valid, input kind, input token_length, input start_line,
		input start_column, input keyword_index, input punct_byte,
		input last_of_run, output ready
	);
endinterface

### src/sctok_scan.sv
// sctok_scan: scanner state (mode, line/column, token start, length,
// keyword candidates) and the zero to two token reports of one byte.
// Depends on sctok_pkg.
module sctok_scan import sctok_pkg::*; #(
	parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
	parameter int unsigned LENGTH_BITS   = LENGTH_BITS_DEF,
	localparam int unsigned RES_BITS     = 3 + LENGTH_BITS + 2 * POSITION_BITS + 3 + 8 + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          ch,
	input  logic                is_end,
	output logic [1:0]          res_cnt,
	output logic [RES_BITS-1:0] res0,
	output logic [RES_BITS-1:0] res1
);

	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
	localparam logic [LENGTH_BITS-1:0]   LEN_MAX = {LENGTH_BITS{1'b1}};
	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
	localparam logic [LENGTH_BITS-1:0]   LEN_ONE = LENGTH_BITS'(1);

	scan_mode_t               mode_q, mode_d;
	logic [POSITION_BITS-1:0] line_q, line_d;
	logic [POSITION_BITS-1:0] col_q, col_d;
	logic [POSITION_BITS-1:0] start_col_q, start_col_d;
	logic [LENGTH_BITS-1:0]   len_q, len_d;
	logic [NUM_KW-1:0]        cand_q, cand_d;

	logic                     extend_c;
	logic [NUM_KW-1:0]        kw_next;
	logic [NUM_KW-1:0]        kw_first;
	logic [LENGTH_BITS-1:0]   len_inc;
	logic [POSITION_BITS-1:0] line_adv, col_adv;
	logic                     pend_valid;
	kind_t                    pend_kind;
	kw_idx_t                  pend_kw;
	logic [RES_BITS-1:0]      pend_res;
	logic [RES_BITS-1:0]      eof_res;
	logic [RES_BITS-1:0]      punct_res;
	logic                     is_punct;

	// Decide whether the byte continues the pending token
	always_comb begin
		unique case (mode_q)
			SCAN_IDENT:  extend_c = is_word(ch);
			SCAN_NUMBER: extend_c = is_digit(ch);
			default:     extend_c = 1'b0;
		endcase
	end

	// Keyword matcher: compare the byte at the current token position
	always_comb begin
		for (int i = 0; i < NUM_KW; i++) begin
			kw_next[i]  = (len_q < LENGTH_BITS'(KW_LEN[i])) &&
				(KW_CHARS[i][len_q[2:0]] == ch);
			kw_first[i] = (KW_CHARS[i][0] == ch);
		end
	end

	// Classify the pending token; a later keyword wins
	always_comb begin
		pend_kind = KIND_IDENT;
		pend_kw   = kw_idx_t'(0);
		for (int i = 0; i < NUM_KW; i++) begin
			if (cand_q[i] && (len_q == LENGTH_BITS'(KW_LEN[i]))) begin
				pend_kind = KIND_KEYWORD;
				pend_kw   = kw_idx_t'(i);
			end
		end
		unique case (mode_q)
			SCAN_IDENT:  pend_valid = 1'b1;
			SCAN_NUMBER: begin
				pend_valid = 1'b1;
				pend_kind  = KIND_NUMBER;
				pend_kw    = kw_idx_t'(0);
			end
			default:     pend_valid = 1'b0;
		endcase
	end

	// Saturating counters
	assign len_inc  = (len_q == LEN_MAX) ? len_q : len_q + LEN_ONE;
	assign line_adv = (ch == CHAR_NEWLINE) ?
		((line_q == POS_MAX) ? line_q : line_q + POS_ONE) : line_q;
	assign col_adv  = (ch == CHAR_NEWLINE) ? POS_ONE :
		((col_q == POS_MAX) ? col_q : col_q + POS_ONE);

	assign is_punct = !is_space(ch) && !is_word(ch);

	// Build the candidate reports
	assign pend_res  = {pend_kind, len_q, line_q, start_col_q, pend_kw, 8'h00, 1'b0};
	assign eof_res   = {KIND_EOF, LENGTH_BITS'(0), line_q, col_q, kw_idx_t'(0), 8'h00,
		1'b1};
	assign punct_res = {KIND_PUNCT, LEN_ONE, line_q, col_q, kw_idx_t'(0), ch, 1'b1};

	// Select the reports of this byte; flag the final one
	always_comb begin
		res_cnt = 2'd0;
		res0    = pend_res;
		res1    = eof_res;
		if (is_end) begin
			if (pend_valid) begin
				res_cnt = 2'd2;
			end else begin
				res_cnt = 2'd1;
				res0    = eof_res;
			end
		end else if (!extend_c) begin
			if (pend_valid && is_punct) begin
				res_cnt = 2'd2;
				res1    = punct_res;
			end else if (pend_valid) begin
				res_cnt = 2'd1;
				res0    = {pend_res[RES_BITS-1:1], 1'b1};
			end else if (is_punct) begin
				res_cnt = 2'd1;
				res0    = punct_res;
			end
		end
	end

	// Next scanner state
	always_comb begin
		mode_d      = mode_q;
		line_d      = line_q;
		col_d       = col_q;
		start_col_d = start_col_q;
		len_d       = len_q;
		cand_d      = cand_q;
		if (is_end) begin
			mode_d      = SCAN_IDLE;
			line_d      = POS_ONE;
			col_d       = POS_ONE;
			start_col_d = POS_ONE;
			len_d       = LENGTH_BITS'(0);
			cand_d      = '1;
		end else if (extend_c) begin
			if (mode_q == SCAN_IDENT) begin
				cand_d = cand_q & kw_next;
			end
			len_d  = len_inc;
			line_d = line_adv;
			col_d  = col_adv;
		end else begin
			mode_d = SCAN_IDLE;
			if (is_alpha(ch) || (ch == CHAR_UNDERSCORE)) begin
				mode_d      = SCAN_IDENT;
				start_col_d = col_q;
				len_d       = LEN_ONE;
				cand_d      = kw_first;
			end else if (is_digit(ch)) begin
				mode_d      = SCAN_NUMBER;
				start_col_d = col_q;
				len_d       = LEN_ONE;
				cand_d      = '1;
			end
			line_d = line_adv;
			col_d  = col_adv;
		end
	end

	// State registers, advanced once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= SCAN_IDLE;
			line_q      <= POS_ONE;
			col_q       <= POS_ONE;
			start_col_q <= POS_ONE;
			len_q       <= LENGTH_BITS'(0);
			cand_q      <= '1;
		end else if (step) begin
			mode_q      <= mode_d;
			line_q      <= line_d;
			col_q       <= col_d;
			start_col_q <= start_col_d;
			len_q       <= len_d;
			cand_q      <= cand_d;
		end
	end

	// A token in progress always holds at least one byte
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != SCAN_IDLE) |-> (len_q != LENGTH_BITS'(0)))
		else $error("token in progress with zero length");

	// End of source returns the scanner to its reset position
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(step && is_end) |=> (mode_q == SCAN_IDLE) && (line_q == POS_ONE) &&
		(col_q == POS_ONE))
		else $error("end of source did not reset scanner");

	// A pair of reports always closes on the second
	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_cnt == 2'd2) |-> (res1[0] && !res0[0]))
		else $error("last flag misplaced on report pair");

endmodule

### src/sctok_rq.sv
// sctok_rq: small result queue that takes up to two reports a cycle and
// hands out one per pop. Depends on sctok_pkg for depth and status type.
module sctok_rq import sctok_pkg::*; #(
	parameter int unsigned W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [1:0]   push_cnt,
	input  logic [W-1:0] d0,
	input  logic [W-1:0] d1,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] head,
	output rq_stat_t     stat
);

	logic [W-1:0]           mem_q [RQ_DEPTH];
	logic [RQ_PTR_BITS-1:0] wr_q, rd_q;
	logic [RQ_PTR_BITS-1:0] wr_nxt;
	logic [RQ_LVL_BITS-1:0] level_q;

	assign wr_nxt     = wr_q + RQ_PTR_BITS'(1);
	assign valid      = (level_q != RQ_LVL_BITS'(0));
	assign head       = mem_q[rd_q];
	assign stat.level = level_q;
	assign stat.room  = (level_q <= RQ_LVL_BITS'(RQ_DEPTH - 2));

	// Store pushed reports
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_q] <= d0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_nxt] <= d1;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			wr_q    <= wr_q + RQ_PTR_BITS'(push_cnt);
			rd_q    <= rd_q + RQ_PTR_BITS'(pop);
			level_q <= level_q + RQ_LVL_BITS'(push_cnt) - RQ_LVL_BITS'(pop);
		end
	end

endmodule

### src/source_char_tokenizer_unit.sv
// source_char_tokenizer_unit: top level of the streaming tokenizer.
// Depends on sctok_pkg, sctok_byte_if, sctok_tok_if, sctok_scan, sctok_rq.
//
//   channel   dir  item                     fields
//   byte_ch   in   one source byte / end    ch, is_end
//   tok_ch    out  one token report         kind, token_length, start_line,
//                                           start_column, keyword_index,
//                                           punct_byte, last_of_run
//
// One byte is accepted per cycle. From the input register the scanner
// updates its state and writes zero, one or two reports into a four-entry
// queue; reports leave one per cycle while tok_ch is ready, so the
// sustained rate is one byte per cycle while bytes average at most one token.
// The input register holds its byte whenever the queue lacks room for two.
// Reset clears the scanner to line 1, column 1 and empties the queue.
module source_char_tokenizer_unit import sctok_pkg::*; #(
	parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
	parameter int unsigned LENGTH_BITS   = LENGTH_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	sctok_byte_if.sink  byte_ch,
	sctok_tok_if.source tok_ch
);

	localparam int unsigned RES_BITS = 3 + LENGTH_BITS + 2 * POSITION_BITS + 3 + 8 + 1;
	localparam int unsigned PB_LO    = 1;
	localparam int unsigned KW_LO    = PB_LO + 8;
	localparam int unsigned COL_LO   = KW_LO + 3;
	localparam int unsigned LINE_LO  = COL_LO + POSITION_BITS;
	localparam int unsigned LEN_LO   = LINE_LO + POSITION_BITS;
	localparam int unsigned KIND_LO  = LEN_LO + LENGTH_BITS;

	logic                valid_s1;
	logic [7:0]          ch_s1;
	logic                end_s1;
	logic                move_s1;
	logic                take;
	logic [1:0]          res_cnt;
	logic [RES_BITS-1:0] res0, res1;
	logic [RES_BITS-1:0] head;
	rq_stat_t            rq_stat;

	// Input stage moves on when the queue can take two reports
	assign move_s1       = valid_s1 && rq_stat.room;
	assign byte_ch.ready = !valid_s1 || rq_stat.room;
	assign take          = byte_ch.valid && byte_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the item payload
	always_ff @(posedge clk) begin
		if (take) begin
			ch_s1  <= byte_ch.ch;
			end_s1 <= byte_ch.is_end;
		end
	end

	sctok_scan #(
		.POSITION_BITS(POSITION_BITS),
		.LENGTH_BITS  (LENGTH_BITS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (move_s1),
		.ch     (ch_s1),
		.is_end (end_s1),
		.res_cnt(res_cnt),
		.res0   (res0),
		.res1   (res1)
	);

	sctok_rq #(
		.W(RES_BITS)
	) u_rq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_cnt(move_s1 ? res_cnt : 2'd0),
		.d0      (res0),
		.d1      (res1),
		.pop     (tok_ch.valid && tok_ch.ready),
		.valid   (tok_ch.valid),
		.head    (head),
		.stat    (rq_stat)
	);

	// Unpack the queue head onto the token channel
	assign tok_ch.kind          = head[KIND_LO +: 3];
	assign tok_ch.token_length  = head[LEN_LO +: LENGTH_BITS];
	assign tok_ch.start_line    = head[LINE_LO +: POSITION_BITS];
	assign tok_ch.start_column  = head[COL_LO +: POSITION_BITS];
	assign tok_ch.keyword_index = head[KW_LO +: 3];
	assign tok_ch.punct_byte    = head[PB_LO +: 8];
	assign tok_ch.last_of_run   = head[0];

	// A byte waiting on a full queue stays put
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !rq_stat.room) |=> (valid_s1 && $stable(ch_s1) && $stable(end_s1)))
		else $error("input stage lost its byte while stalled");

	// Queue never overfills
	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_stat.level <= RQ_LVL_BITS'(RQ_DEPTH))
		else $error("result queue overflow");

	// End token always closes its run
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_ch.valid && (tok_ch.kind == KIND_EOF)) |-> tok_ch.last_of_run)
		else $error("end token without last flag");

endmodule
